/* rtl/fpc_pkg.sv */
// shared types, codes and constants for the frame pixel convert and place block
// no dependencies
package fpc_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;
  localparam int DIM_W           = 11;
  localparam int COORD_W         = 10;
  localparam int RAW_W           = 32;
  localparam int IDX_W           = 20;
  localparam int CHAN_W          = 8;
  localparam int FMT_W           = 2;
  localparam int CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_WIDTH    = 3'd0,
    REG_OUT_HEIGHT   = 3'd1,
    REG_SRC_WIDTH    = 3'd2,
    REG_SRC_HEIGHT   = 3'd3,
    REG_PIXEL_FORMAT = 3'd4
  } cfg_reg_e;

  typedef enum logic [FMT_W-1:0] {
    FMT_RGB1555 = 2'd0,
    FMT_XRGB8888 = 2'd1,
    FMT_RGB565  = 2'd2,
    FMT_NONE    = 2'd3
  } pix_fmt_e;

  localparam logic [DIM_W-1:0]  RST_OUT_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0]  RST_OUT_HEIGHT = 11'd224;
  localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 11'd224;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE   = 8'hFF;

  typedef struct packed {
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic [RAW_W-1:0]   raw_pixel;
  } in_item_t;

  typedef struct packed {
    logic              write_enable;
    logic [IDX_W-1:0]  dest_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } result_t;

  // placement geometry derived from the dimension registers
  typedef struct packed {
    logic [DIM_W-1:0] ow;
    logic [DIM_W-1:0] off_x;
    logic [DIM_W-1:0] off_y;
    logic [DIM_W-1:0] cw;
    logic [DIM_W-1:0] ch;
    pix_fmt_e         fmt;
  } geom_t;

endpackage

/* rtl/fpc_cfg.sv */
// configuration registers and derived placement geometry
// depends on fpc_pkg
module fpc_cfg import fpc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output geom_t                geom
);

  localparam int CMP_W = DIM_W + 2;

  logic [DIM_W-1:0] out_width;
  logic [DIM_W-1:0] out_height;
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  pix_fmt_e         pixel_format;

  logic [DIM_W-1:0] ow, oh, sw, sh;
  logic [DIM_W-1:0] diff_x, diff_y;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] vw;
    vw = CMP_W'(v);
    if (vw > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    else return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width    <= RST_OUT_WIDTH;
      out_height   <= RST_OUT_HEIGHT;
      src_width    <= RST_SRC_WIDTH;
      src_height   <= RST_SRC_HEIGHT;
      pixel_format <= FMT_RGB1555;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUT_WIDTH:    out_width    <= cfg_data;
        REG_OUT_HEIGHT:   out_height   <= cfg_data;
        REG_SRC_WIDTH:    src_width    <= cfg_data;
        REG_SRC_HEIGHT:   src_height   <= cfg_data;
        REG_PIXEL_FORMAT: pixel_format <= pix_fmt_e'(cfg_data[FMT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    ow     = clamp_dim(out_width);
    oh     = clamp_dim(out_height);
    sw     = clamp_dim(src_width);
    sh     = clamp_dim(src_height);
    diff_x = ow - sw;
    diff_y = oh - sh;
    geom.ow    = ow;
    geom.fmt   = pixel_format;
    // smaller source is centred, larger one cropped from the top-left
    geom.off_x = (sw < ow) ? (diff_x >> 1) : '0;
    geom.off_y = (sh < oh) ? (diff_y >> 1) : '0;
    geom.cw    = (sw < ow) ? sw : ow;
    geom.ch    = (sh < oh) ? sh : oh;
  end

endmodule

/* rtl/fpc_datapath.sv */
// four-stage pixel pipeline: capture, window and colour, multiply, index add
// depends on fpc_pkg
module fpc_datapath import fpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  input  geom_t    geom,
  output logic     out_valid,
  output result_t  out_item
);

  localparam int SUM_W  = DIM_W;
  localparam int PROD_W = 2 * DIM_W;
  localparam int ACC_W  = PROD_W + 1;

  // stage 1: item and geometry captured
  logic     v1;
  in_item_t s1_item;
  geom_t    s1_geom;

  // stage 2: window test, coordinate offsets, colour
  logic              v2;
  logic              s2_we;
  logic [SUM_W-1:0]  s2_row_sum;
  logic [SUM_W-1:0]  s2_col_sum;
  logic [DIM_W-1:0]  s2_ow;
  logic [CHAN_W-1:0] s2_r, s2_g, s2_b, s2_a;

  // stage 3: row times width
  logic              v3;
  logic              s3_we;
  logic [PROD_W-1:0] s3_prod;
  logic [SUM_W-1:0]  s3_col_sum;
  logic [CHAN_W-1:0] s3_r, s3_g, s3_b, s3_a;

  logic              in_window;
  logic [CHAN_W-1:0] r_c, g_c, b_c, a_c;
  logic [15:0]       h;
  logic [ACC_W-1:0]  idx_sum;

  always_comb begin
    in_window = ({1'b0, s1_item.src_col} < s1_geom.cw) &&
                ({1'b0, s1_item.src_row} < s1_geom.ch);
    h   = s1_item.raw_pixel[15:0];
    r_c = '0;
    g_c = '0;
    b_c = '0;
    a_c = '0;
    unique case (s1_geom.fmt)
      FMT_RGB1555: begin
        r_c = {h[14:10], 3'b000};
        g_c = {h[9:5], 3'b000};
        b_c = {h[4:0], 3'b000};
        a_c = ALPHA_OPAQUE;
      end
      FMT_XRGB8888: begin
        r_c = s1_item.raw_pixel[23:16];
        g_c = s1_item.raw_pixel[15:8];
        b_c = s1_item.raw_pixel[7:0];
        a_c = ALPHA_OPAQUE;
      end
      FMT_RGB565: begin
        r_c = {h[15:11], 3'b000};
        g_c = {h[10:5], 2'b00};
        b_c = {h[4:0], 3'b000};
        a_c = ALPHA_OPAQUE;
      end
      default: ;
    endcase
    idx_sum = ACC_W'(s3_prod) + ACC_W'(s3_col_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= in_item;
    s1_geom <= geom;

    s2_we      <= in_window;
    s2_row_sum <= SUM_W'(s1_item.src_row) + s1_geom.off_y;
    s2_col_sum <= SUM_W'(s1_item.src_col) + s1_geom.off_x;
    s2_ow      <= s1_geom.ow;
    s2_r       <= in_window ? r_c : '0;
    s2_g       <= in_window ? g_c : '0;
    s2_b       <= in_window ? b_c : '0;
    s2_a       <= in_window ? a_c : '0;

    s3_we      <= s2_we;
    s3_prod    <= s2_row_sum * s2_ow;
    s3_col_sum <= s2_col_sum;
    s3_r       <= s2_r;
    s3_g       <= s2_g;
    s3_b       <= s2_b;
    s3_a       <= s2_a;

    out_item.write_enable <= s3_we;
    out_item.dest_index   <= s3_we ? idx_sum[IDX_W-1:0] : '0;
    out_item.red          <= s3_r;
    out_item.green        <= s3_g;
    out_item.blue         <= s3_b;
    out_item.alpha        <= s3_a;
  end

  // every result must trace back to an item that entered the pipeline earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, 4))
    else $error("result without a matching item");

  // pixels outside the window carry an all-zero payload
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.write_enable) |->
      (out_item.dest_index == '0 && out_item.red == '0 && out_item.green == '0 &&
       out_item.blue == '0 && out_item.alpha == '0))
    else $error("payload not cleared outside window");

  // alpha is either opaque or zero, and zero alpha means zero colour
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.alpha != ALPHA_OPAQUE) |->
      (out_item.alpha == '0 && out_item.red == '0 && out_item.green == '0 &&
       out_item.blue == '0))
    else $error("colour present without alpha");

endmodule

/* rtl/frame_pixel_convert_and_place_core.sv */
// top level of the frame pixel convert and place block
// depends on fpc_pkg, fpc_cfg and fpc_datapath
//
// usage
//   input: drive start high with pixel_in (column, row, raw value) for one
//   cycle per pixel; an item is taken at each edge with start high and busy
//   low. busy is high during reset and falls at the first edge with rst
//   low; then one item is taken every clock cycle that start is high.
//   output: every item gives exactly one result on result, marked by
//   result_valid for a single cycle, in input order. write_enable in the
//   result says whether the pixel falls in the copy window; outside it the
//   whole payload is zero. dest_index is row times output width plus column
//   after centring, wrapped to 20 bits.
//   configuration: cfg_we, cfg_index, cfg_data write one register per edge;
//   write only while no items are in flight.
//   pipeline: four register stages (capture, window and colour, row by width
//   multiply, index add), with result_valid and the result both registered
//   by the index add stage. rate is one item per cycle, as no stage ever
//   holds
//   reset: synchronous rst clears the pipeline valids and loads the
//   dimension registers with 320 x 224 for both frames and format 0RGB1555
//   the receiver cannot stall; results are dropped if not taken on the cycle
module frame_pixel_convert_and_place_core import fpc_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             pixel_in,
  output logic                 result_valid,
  output result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  geom_t geom;
  logic  accept;

  // held high through reset, released the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  // register file and clamped, centred geometry
  fpc_cfg #(
    .MAX_DIM(MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  // pixel pipeline
  fpc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_item   (pixel_in),
    .geom      (geom),
    .out_valid (result_valid),
    .out_item  (result)
  );

endmodule

/* tb/fpc_result_checker.sv */
`timescale 1ns / 100ps
// result checker for the frame pixel convert and place block
// follows register writes, predicts every accepted item and compares; needs fpc_pkg
module fpc_result_checker import fpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             pixel_in,
  input  logic                 result_valid,
  input  result_t              result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   written
);

  logic [DIM_W-1:0] out_w, out_h, src_w, src_h;
  pix_fmt_e         fmt;
  result_t          placed_pixels_due[$];

  function automatic int clamp_dim(logic [DIM_W-1:0] d);
    return (d > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(d);
  endfunction

  function automatic result_t convert_and_place(in_item_t px);
    int          ow, oh, sw, sh, off_x, off_y, idx;
    logic [15:0] h;
    result_t     r;
    ow    = clamp_dim(out_w);
    oh    = clamp_dim(out_h);
    sw    = clamp_dim(src_w);
    sh    = clamp_dim(src_h);
    off_x = (sw < ow) ? (ow - sw) / 2 : 0;
    off_y = (sh < oh) ? (oh - sh) / 2 : 0;
    r     = '0;
    // outside the copy window the whole payload stays zero
    if (int'(px.src_col) >= ((sw < ow) ? sw : ow) ||
        int'(px.src_row) >= ((sh < oh) ? sh : oh))
      return r;
    h = px.raw_pixel[15:0];
    case (fmt)
      FMT_RGB1555: begin
        r.red   = {h[14:10], 3'b000};
        r.green = {h[9:5], 3'b000};
        r.blue  = {h[4:0], 3'b000};
        r.alpha = ALPHA_OPAQUE;
      end
      FMT_XRGB8888: begin
        r.red   = px.raw_pixel[23:16];
        r.green = px.raw_pixel[15:8];
        r.blue  = px.raw_pixel[7:0];
        r.alpha = ALPHA_OPAQUE;
      end
      FMT_RGB565: begin
        r.red   = {h[15:11], 3'b000};
        r.green = {h[10:5], 2'b00};
        r.blue  = {h[4:0], 3'b000};
        r.alpha = ALPHA_OPAQUE;
      end
      default: ;
    endcase
    idx            = (int'(px.src_row) + off_y) * ow + int'(px.src_col) + off_x;
    r.write_enable = 1'b1;
    r.dest_index   = idx[IDX_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_w      = RST_OUT_WIDTH;
      out_h      = RST_OUT_HEIGHT;
      src_w      = RST_SRC_WIDTH;
      src_h      = RST_SRC_HEIGHT;
      fmt        = FMT_RGB1555;
      mismatches = 0;
      written    = 0;
      placed_pixels_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OUT_WIDTH:    out_w = cfg_data;
          REG_OUT_HEIGHT:   out_h = cfg_data;
          REG_SRC_WIDTH:    src_w = cfg_data;
          REG_SRC_HEIGHT:   src_h = cfg_data;
          REG_PIXEL_FORMAT: fmt   = pix_fmt_e'(cfg_data[FMT_W-1:0]);
          default: ;
        endcase
      end
      if (result_valid) begin
        if (placed_pixels_due.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = placed_pixels_due.pop_front();
          if (result.write_enable) written++;
          if (result.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, got %0d", want.write_enable,
                   result.write_enable);
            mismatches++;
          end
          if (result.dest_index !== want.dest_index) begin
            $error("dest_index: expected %0d, got %0d", want.dest_index,
                   result.dest_index);
            mismatches++;
          end
          if (result.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, result.red);
            mismatches++;
          end
          if (result.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, result.green);
            mismatches++;
          end
          if (result.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, result.blue);
            mismatches++;
          end
          if (result.alpha !== want.alpha) begin
            $error("alpha: expected %0d, got %0d", want.alpha, result.alpha);
            mismatches++;
          end
        end
      end
      if (start && !busy) placed_pixels_due.push_back(convert_and_place(pixel_in));
    end
    pending = placed_pixels_due.size();
  end

endmodule

/* tb/tb_frame_pixel_convert_and_place_core.sv */
`timescale 1ns / 100ps
// testbench top for frame_pixel_convert_and_place_core: clock, reset, stimulus, verdict
// needs fpc_pkg, the block itself and fpc_result_checker
module tb_frame_pixel_convert_and_place_core;
  import fpc_pkg::*;

  localparam int LATENCY     = 4;       // item taken to result
  localparam int TOTAL_ITEMS = 1450;
  localparam int CALM_TAIL   = 200;     // last items get no random idle bursts
  localparam int CYCLE_LIMIT = 200000;  // several times the slowest legal run

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_item_t             pixel_in;
  logic                 result_valid;
  result_t              result;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  int mismatches, pending, written;
  int items_sent     = 0;
  int settings_used  = 1;   // reset values count as the first setting
  int cycle_count    = 0;

  // the geometry last written, kept only to aim coordinates at the copy window
  logic [DIM_W-1:0] set_ow = RST_OUT_WIDTH;
  logic [DIM_W-1:0] set_oh = RST_OUT_HEIGHT;
  logic [DIM_W-1:0] set_sw = RST_SRC_WIDTH;
  logic [DIM_W-1:0] set_sh = RST_SRC_HEIGHT;

  frame_pixel_convert_and_place_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  fpc_result_checker pixel_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .written      (written)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // present one item and hold it until the block takes it; start is left high
  // so the next item can follow on the very next edge
  task automatic send_pixel(in_item_t it);
    start    <= 1'b1;
    pixel_in <= it;
    items_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // one register write per edge; the caller drops cfg_we after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // wait until every predicted result is back, then let the pipe run empty
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // full register set; now and then a write to an unused index, which must be ignored
  task automatic load_frame_regs(logic [DIM_W-1:0] ow, logic [DIM_W-1:0] oh,
                                 logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh,
                                 logic [DIM_W-1:0] fmt_word);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_PIXEL_FORMAT, fmt_word);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(int'(REG_PIXEL_FORMAT) +
                $urandom_range(1, (1 << CFG_IDX_W) - 1 - int'(REG_PIXEL_FORMAT))),
                DIM_W'($urandom));
    cfg_we <= 1'b0;
    set_ow = ow;
    set_oh = oh;
    set_sw = sw;
    set_sh = sh;
    settings_used++;
  endtask

  // copy window extent along one axis, saturating oversized registers
  function automatic int window_span(logic [DIM_W-1:0] s, logic [DIM_W-1:0] o);
    int se, oe;
    se = (s > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(s);
    oe = (o > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(o);
    return (se < oe) ? se : oe;
  endfunction

  // mostly near or inside the window (one past the edge included), the rest
  // anywhere in the coordinate range; a zero span gives fully random coordinates
  function automatic in_item_t rand_item(int span_c, int span_r);
    in_item_t it;
    int       top;
    top       = (1 << COORD_W) - 1;
    it.src_col = (span_c > 0 && $urandom_range(0, 3) != 0) ?
                 COORD_W'($urandom_range(0, (span_c > top) ? top : span_c)) :
                 COORD_W'($urandom);
    it.src_row = (span_r > 0 && $urandom_range(0, 3) != 0) ?
                 COORD_W'($urandom_range(0, (span_r > top) ? top : span_r)) :
                 COORD_W'($urandom);
    case ($urandom_range(0, 9))
      0:       it.raw_pixel = '0;
      1:       it.raw_pixel = '1;
      default: it.raw_pixel = $urandom;
    endcase
    return it;
  endfunction

  // dimension register value: mostly small frames, with zero, one, the
  // maximum and oversized values mixed in
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DIM_W'(1);
      2:       return DIM_W'(MAX_DIM_DEFAULT);
      3:       return DIM_W'($urandom_range(MAX_DIM_DEFAULT + 1, (1 << DIM_W) - 1));
      4, 5, 6: return DIM_W'($urandom_range(2, MAX_DIM_DEFAULT - 1));
      default: return DIM_W'($urandom_range(1, 48));
    endcase
  endfunction

  // a run of random items under the current setting; idling density is drawn
  // per run so that some runs have none at all
  task automatic run_phase(int n, bit hold_mid);
    int span_c, span_r, idle_rate;
    span_c    = window_span(set_sw, set_ow);
    span_r    = window_span(set_sh, set_oh);
    idle_rate = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        // sender holds off until every result so far is back
        start <= 1'b0;
        drain();
      end else if (idle_rate != 0 && items_sent < TOTAL_ITEMS - CALM_TAIL &&
                   $urandom_range(1, 8) <= idle_rate) begin
        // idle burst; junk on the data lines must be ignored
        start    <= 1'b0;
        pixel_in <= rand_item(0, 0);
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      send_pixel(rand_item(span_c, span_r));
    end
    start <= 1'b0;
    drain();
  endtask

  initial begin
    pix_fmt_e fmt_list[3];
    int       n;
    bit       first_random;
    fmt_list     = '{FMT_XRGB8888, FMT_RGB565, FMT_NONE};
    first_random = 1'b1;

    rst       <= 1'b1;
    start     <= 1'b0;
    pixel_in  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_OUT_WIDTH;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part under reset values: 320 x 224 both frames, 0RGB1555
    send_pixel({10'd0, 10'd0, 32'h0000_0000});
    send_pixel({10'd0, 10'd0, 32'hFFFF_FFFF});
    send_pixel({10'd319, 10'd223, 32'h0000_7FFF});   // last pixel in the window
    send_pixel({10'd319, 10'd223, 32'h0000_8000});   // 1555 top bit must be dropped
    send_pixel({10'd160, 10'd112, 32'hABCD_5555});   // upper half ignored
    send_pixel({10'd1, 10'd2, 32'h0000_7C00});       // red field only
    send_pixel({10'd3, 10'd4, 32'h0000_03E0});       // green field only
    send_pixel({10'd5, 10'd6, 32'h0000_001F});       // blue field only
    send_pixel({10'd320, 10'd0, 32'hFFFF_FFFF});     // just right of the window
    send_pixel({10'd0, 10'd224, 32'hFFFF_FFFF});     // just below the window
    send_pixel({10'd1023, 10'd1023, 32'hFFFF_FFFF}); // coordinate extremes
    start <= 1'b0;
    drain();

    // the other formats, unsupported one included, same geometry
    foreach (fmt_list[k]) begin
      write_reg(REG_PIXEL_FORMAT, DIM_W'(fmt_list[k]));
      cfg_we <= 1'b0;
      send_pixel({10'd0, 10'd0, 32'hFFFF_FFFF});
      send_pixel({10'd319, 10'd223, 32'h00FF_8001});
      send_pixel({10'd17, 10'd9, 32'($urandom)});
      start <= 1'b0;
      drain();
    end

    // fixed corner settings
    load_frame_regs(11'd2047, 11'd2047, 11'd2047, 11'd2047, DIM_W'(FMT_XRGB8888)); // saturate
    run_phase(40, 1'b0);
    load_frame_regs(11'd1024, 11'd1024, 11'd1024, 11'd1024, DIM_W'(FMT_RGB1555));
    run_phase(40, 1'b0);
    load_frame_regs(11'd1, 11'd1, 11'd1024, 11'd1024, DIM_W'(FMT_RGB565));        // heavy crop
    run_phase(40, 1'b0);
    load_frame_regs(11'd1024, 11'd1024, 11'd1, 11'd1, DIM_W'(FMT_RGB1555));       // big offset
    run_phase(40, 1'b0);
    load_frame_regs(11'd321, 11'd200, 11'd100, 11'd7, DIM_W'(FMT_NONE));          // odd margins
    run_phase(40, 1'b0);
    load_frame_regs(11'd64, 11'd48, 11'd0, 11'd48, DIM_W'(FMT_XRGB8888));         // empty window
    run_phase(40, 1'b0);
    load_frame_regs(11'd0, 11'd0, 11'd16, 11'd16, DIM_W'(FMT_RGB565));            // no output frame
    run_phase(40, 1'b0);

    // random settings until the item budget is spent; the format word carries
    // random upper bits that the block must ignore
    while (items_sent < TOTAL_ITEMS) begin
      load_frame_regs(pick_dim(), pick_dim(), pick_dim(), pick_dim(), DIM_W'($urandom));
      n = $urandom_range(30, 120);
      if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
      run_phase(n, first_random || $urandom_range(0, 3) == 0);
      first_random = 1'b0;
    end

    $display("%0d pixels over %0d register settings, %0d written inside the copy window",
             items_sent, settings_used, written);
    $display("all formats, centring, cropping, empty and oversized frames exercised");
    if (mismatches == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
